@@ design/lap4et_pkg.sv @@
package lap4et_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int PixW     = 8;
  localparam int PackW    = 3 * PixW;
  localparam int EdgeW    = 11;
  localparam int MagW     = EdgeW - 1;
  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int ThrW     = 10;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2,
    CfgThresh = 2'd3
  } cfg_idx_t;

  typedef logic [PackW-1:0] pix_t;

  // stage 1: pixel waiting on line store read data
  typedef struct packed {
    pix_t            cur;
    logic [ColW-1:0] col;
    logic            prod;
    logic            last;
  } s1_t;

  // stage 2: per-channel responses
  typedef struct packed {
    logic signed [EdgeW-1:0] v0;
    logic signed [EdgeW-1:0] v1;
    logic signed [EdgeW-1:0] v2;
    logic                    prod;
    logic                    last;
  } lap_t;

  function automatic logic signed [EdgeW-1:0] lap_ch(
    input logic [PixW-1:0] c,
    input logic [PixW-1:0] u,
    input logic [PixW-1:0] d,
    input logic [PixW-1:0] l,
    input logic [PixW-1:0] r
  );
    logic [PixW+1:0] s;
    s = (PixW+2)'(u) + (PixW+2)'(d) + (PixW+2)'(l) + (PixW+2)'(r);
    return $signed({1'b0, c, 2'b00}) - $signed({1'b0, s});
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [EdgeW-1:0] v);
    logic signed [EdgeW-1:0] n;
    n = -v;
    return v[EdgeW-1] ? n[MagW-1:0] : v[MagW-1:0];
  endfunction

endpackage

@@ design/lap4et_if.sv @@
interface lap4et_pix_if;
  import lap4et_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] channel_zero;
  logic [PixW-1:0] channel_one;
  logic [PixW-1:0] channel_two;
  modport source (output valid, channel_zero, channel_one, channel_two, input ready);
  modport sink   (input valid, channel_zero, channel_one, channel_two, output ready);
endinterface

interface lap4et_res_if;
  import lap4et_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [EdgeW-1:0] edge_value;
  logic                    frame_last;
  modport source (output valid, edge_value, frame_last, input ready);
  modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

@@ design/lap4et_line_mem.sv @@
module lap4et_line_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [lap4et_pkg::ColW-1:0] rd_addr,
  output logic [2*lap4et_pkg::PackW-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [lap4et_pkg::ColW-1:0] wr_addr,
  input  logic [2*lap4et_pkg::PackW-1:0] wr_data
);
  import lap4et_pkg::*;

  // entry: {middle line, upper line}
  logic [2*PackW-1:0] mem_r [MaxWidth];
  logic [2*PackW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

@@ design/lap4et_window.sv @@
module lap4et_window (
  input  logic                    clk,
  input  logic                    en,
  input  lap4et_pkg::s1_t         s1,
  input  lap4et_pkg::pix_t        rd_up,
  input  lap4et_pkg::pix_t        rd_mid,
  output lap4et_pkg::lap_t        lap
);
  import lap4et_pkg::*;

  pix_t up0_r, mid0_r, mid1_r, cur0_r;
  lap_t lap_r;
  lap_t lap_nxt;

  always_comb begin
    lap_nxt.v0   = lap_ch(mid0_r[PixW-1:0], up0_r[PixW-1:0], cur0_r[PixW-1:0],
                          mid1_r[PixW-1:0], rd_mid[PixW-1:0]);
    lap_nxt.v1   = lap_ch(mid0_r[2*PixW-1:PixW], up0_r[2*PixW-1:PixW],
                          cur0_r[2*PixW-1:PixW], mid1_r[2*PixW-1:PixW],
                          rd_mid[2*PixW-1:PixW]);
    lap_nxt.v2   = lap_ch(mid0_r[3*PixW-1:2*PixW], up0_r[3*PixW-1:2*PixW],
                          cur0_r[3*PixW-1:2*PixW], mid1_r[3*PixW-1:2*PixW],
                          rd_mid[3*PixW-1:2*PixW]);
    lap_nxt.prod = s1.prod;
    lap_nxt.last = s1.last;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up0_r  <= rd_up;
      mid1_r <= mid0_r;
      mid0_r <= rd_mid;
      cur0_r <= s1.cur;
      lap_r  <= lap_nxt;
    end
  end

  assign lap = lap_r;

endmodule

@@ design/lap4et_select.sv @@
module lap4et_select (
  input  logic                          clk,
  input  logic                          en,
  input  lap4et_pkg::lap_t              lap,
  input  logic                          color_mode,
  input  logic [lap4et_pkg::ThrW-1:0]   threshold,
  output logic signed [lap4et_pkg::EdgeW-1:0] edge_value,
  output logic                          frame_last
);
  import lap4et_pkg::*;

  logic [MagW-1:0]         a0, a1, a2, amax, m;
  logic signed [EdgeW+1:0] sum3;
  logic                    neg;
  logic signed [EdgeW-1:0] edge_nxt;
  logic signed [EdgeW-1:0] edge_r;
  logic                    last_r;

  always_comb begin
    a0   = mag(lap.v0);
    a1   = mag(lap.v1);
    a2   = mag(lap.v2);
    amax = a0;
    if (amax < a1) amax = a1;
    if (amax < a2) amax = a2;
    sum3 = (EdgeW+2)'(lap.v0) + (EdgeW+2)'(lap.v1) + (EdgeW+2)'(lap.v2);
    m    = color_mode ? amax : a0;
    neg  = color_mode ? sum3[EdgeW+1] : lap.v0[EdgeW-1];
    if (m <= MagW'(threshold)) begin
      edge_nxt = '0;
    end else if (neg) begin
      edge_nxt = -$signed({1'b0, m});
    end else begin
      edge_nxt = $signed({1'b0, m});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_r <= edge_nxt;
      last_r <= lap.last;
    end
  end

  assign edge_value = edge_r;
  assign frame_last = last_r;

endmodule

@@ design/laplacian4_edge_threshold.sv @@
// channel  | dir | word
// in_px    | in  | channel_zero, channel_one, channel_two (8 bit each)
// out_edge | out | edge_value (11 bit signed), frame_last
// cfg_*    | in  | index 0 mode, 1 width, 2 height, 3 threshold
// One word accepted per cycle unless the output stalls; a result passes stage 1, stage 2 and output registers.
// Throughput is set by the single read and single write port of the line memory.
// Synchronous reset initialises control state; data registers and line memory are not cleared.
// A stalled output backs up through the three stages to in_px.ready.
module laplacian4_edge_threshold (
  input  logic                              clk,
  input  logic                              rst_n,
  lap4et_pix_if.sink                        in_px,
  lap4et_res_if.source                      out_edge,
  input  logic                              cfg_we,
  input  logic [lap4et_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lap4et_pkg::CfgDataW-1:0]   cfg_data
);
  import lap4et_pkg::*;

  logic               mode_r;
  logic [WidthW-1:0]  width_r;
  logic [HeightW-1:0] height_r;
  logic [ThrW-1:0]    thr_r;
  logic [ColW-1:0]    col_r, col_nxt;
  logic [HeightW-1:0] row_r, row_nxt;
  logic [ColW-1:0]    wm1;
  logic [HeightW-1:0] hm1;

  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_free, s1_free, s1_adv, in_fire;
  s1_t  s1_r, s1_nxt;
  lap_t lap;
  logic [2*PackW-1:0] rd_data;
  logic               mem_we;

  always_comb begin
    if (width_r < WidthW'(3)) begin
      wm1 = ColW'(2);
    end else if (32'(width_r) > MaxWidth) begin
      wm1 = ColW'(MaxWidth - 1);
    end else begin
      wm1 = ColW'(width_r - WidthW'(1));
    end
    if (height_r < HeightW'(3)) begin
      hm1 = HeightW'(2);
    end else begin
      hm1 = height_r - HeightW'(1);
    end
  end

  assign out_free = !out_valid_r || out_edge.ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_fire  = in_px.valid && s1_free;
  assign in_px.ready = s1_free;

  always_comb begin
    s1_nxt.cur  = {in_px.channel_two, in_px.channel_one, in_px.channel_zero};
    s1_nxt.col  = col_r;
    s1_nxt.prod = (row_r >= HeightW'(2)) && (col_r >= ColW'(2));
    s1_nxt.last = (row_r == hm1) && (col_r == wm1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1) ? '0 : row_r + HeightW'(1);
      end else begin
        col_nxt = col_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= WidthW'(640);
      height_r <= HeightW'(480);
      thr_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgMode:   mode_r   <= cfg_data[0];
        CfgWidth:  width_r  <= cfg_data[WidthW-1:0];
        CfgHeight: height_r <= cfg_data[HeightW-1:0];
        CfgThresh: thr_r    <= cfg_data[ThrW-1:0];
        default:   mode_r   <= mode_r;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_fire;
      if (s2_free) s2_valid_r <= s1_valid_r;
      if (out_free) out_valid_r <= s2_valid_r && lap.prod;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign mem_we = s1_adv;

  lap4et_line_mem u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (s1_r.col),
    .wr_data ({s1_r.cur, rd_data[2*PackW-1:PackW]})
  );

  lap4et_window u_win (
    .clk    (clk),
    .en     (s1_adv),
    .s1     (s1_r),
    .rd_up  (rd_data[PackW-1:0]),
    .rd_mid (rd_data[2*PackW-1:PackW]),
    .lap    (lap)
  );

  lap4et_select u_sel (
    .clk        (clk),
    .en         (out_free),
    .lap        (lap),
    .color_mode (mode_r),
    .threshold  (thr_r),
    .edge_value (out_edge.edge_value),
    .frame_last (out_edge.frame_last)
  );

  assign out_edge.valid = out_valid_r;

  a_no_rw_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && in_fire |-> s1_r.col != col_r)
    else $error("line memory read and write hit the same column");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_r))
    else $error("stage 1 word lost while stalled");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_we && col_r == wm1 |=> col_r == '0)
    else $error("column count failed to wrap at line end");

  a_last_only_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && lap.last |-> lap.prod)
    else $error("frame end flag on a border position");

endmodule

@@ tb/tb_laplacian4_edge_threshold.sv @@
`timescale 1ns / 1ps

module tb_laplacian4_edge_threshold;
  import lap4et_pkg::*;

  typedef enum logic {RowPix, RowCfg} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    cfg_idx_t                idx;
    logic [CfgDataW-1:0]     data;
    pix_t                    px;
    logic                    typed;
    logic signed [EdgeW-1:0] want_edge;
    logic                    want_last;
  } step_row_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] edge_value;
    logic                    frame_last;
  } edge_word_t;

  // px = {channel_two, channel_one, channel_zero}
  localparam int NumRows = 32;
  localparam step_row_t StepTable [NumRows] = '{
    // gray, width below 3 and height below 3 both act as 3
    '{RowCfg, CfgWidth,  16'd2,    24'h0,      1'b0, 11'sd0,     1'b0},
    '{RowCfg, CfgHeight, 16'd0,    24'h0,      1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA500, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA5FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA500, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA5FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA500, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA5FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA500, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA5FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h5AA500, 1'b1, -11'sd1020, 1'b1},
    // next frame back to back, inverted pattern
    '{RowPix, CfgMode,   16'd0,    24'hFF00FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF0000, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF00FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF0000, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF00FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF0000, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF00FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF0000, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFF00FF, 1'b1, 11'sd1020,  1'b1},
    // rgb: channel sums negative, so the winning magnitude is negated
    '{RowCfg, CfgMode,   16'd1,    24'h0,      1'b0, 11'sd0,     1'b0},
    '{RowCfg, CfgThresh, 16'd1019, 24'h0,      1'b0, 11'sd0,     1'b0},
    '{RowCfg, CfgWidth,  16'd3,    24'h0,      1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h808080, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFFFF00, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h808080, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFFFF00, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h0000FF, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFFFF00, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h808080, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'hFFFF00, 1'b0, 11'sd0,     1'b0},
    '{RowPix, CfgMode,   16'd0,    24'h808080, 1'b1, -11'sd1020, 1'b1}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  lap4et_pix_if pix_bus ();
  lap4et_res_if edge_bus ();

  laplacian4_edge_threshold u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (pix_bus),
    .out_edge  (edge_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic               cur_mode;
  logic [WidthW-1:0]  cur_width;
  logic [HeightW-1:0] cur_height;
  logic [ThrW-1:0]    cur_thr;
  pix_t               upper_line  [MaxWidth];
  pix_t               middle_line [MaxWidth];
  pix_t               win_cols    [6];
  int                 col_pos;
  int                 row_pos;

  edge_word_t edge_expected [$];
  edge_word_t seen_word;
  edge_word_t due_word;

  bit steady;
  int hold_left;
  int flat_level;
  int fail_count;
  int n_words;
  int n_checked;
  int n_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("timeout with %0d edge words outstanding", edge_expected.size());
    $display("tb_laplacian4_edge_threshold NOT OK");
    $finish;
  end

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int eff_width();
    int w;
    w = cur_width;
    if (w < 3) w = 3;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cur_height;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic int chan_lap(pix_t ctr, pix_t u, pix_t d, pix_t l, pix_t r, int k);
    return 4 * int'(ctr[8*k +: 8]) - int'(u[8*k +: 8]) - int'(d[8*k +: 8])
           - int'(l[8*k +: 8]) - int'(r[8*k +: 8]);
  endfunction

  // returns 1 when the word completes an interior position
  function automatic bit predict_edge(pix_t px, output edge_word_t res);
    int   w, h, c, v, v0, v1, v2, a;
    pix_t up, mid;
    bit   made;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    if (c >= w) c = w - 1;
    up = upper_line[c];
    mid = middle_line[c];
    made = 1'b0;
    res = '0;
    if (row_pos >= 2 && c >= 2) begin
      v0 = chan_lap(win_cols[2], win_cols[0], win_cols[4], win_cols[3], mid, 0);
      if (!cur_mode) begin
        v = v0;
      end else begin
        v1 = chan_lap(win_cols[2], win_cols[0], win_cols[4], win_cols[3], mid, 1);
        v2 = chan_lap(win_cols[2], win_cols[0], win_cols[4], win_cols[3], mid, 2);
        a = abs_int(v0);
        if (abs_int(v1) > a) a = abs_int(v1);
        if (abs_int(v2) > a) a = abs_int(v2);
        v = (v0 + v1 + v2 < 0) ? -a : a;
      end
      if (abs_int(v) <= int'(cur_thr)) v = 0;
      res.edge_value = v[EdgeW-1:0];
      res.frame_last = (row_pos == h - 1 && c == w - 1);
      made = 1'b1;
    end
    win_cols[1] = win_cols[0];
    win_cols[3] = win_cols[2];
    win_cols[5] = win_cols[4];
    win_cols[0] = up;
    win_cols[2] = mid;
    win_cols[4] = px;
    upper_line[c] = mid;
    middle_line[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    col_pos = c;
    return made;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t gen_pixel(int style);
    pix_t px;
    for (int k = 0; k < 3; k++) begin
      case (style)
        0: px[8*k +: 8] = 8'($urandom_range(0, 255));
        1: begin
          if ($urandom_range(0, 2) != 0) px[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else px[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        default: px[8*k +: 8] = 8'(flat_level + int'($urandom_range(0, 6)));
      endcase
    end
    return px;
  endfunction

  task automatic settle_pipe();
    @(negedge clk);
    pix_bus.valid = 1'b0;
    while (edge_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    settle_pipe();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CfgMode:   cur_mode = val[0];
      CfgWidth:  cur_width = val[WidthW-1:0];
      CfgHeight: cur_height = val[HeightW-1:0];
      CfgThresh: cur_thr = val[ThrW-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    n_writes++;
  endtask

  task automatic push_word(pix_t px, bit typed, edge_word_t typed_word);
    int         gap;
    edge_word_t calc;
    bit         made;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      pix_bus.valid = 1'b0;
      {pix_bus.channel_two, pix_bus.channel_one, pix_bus.channel_zero} = PackW'($urandom());
    end
    @(negedge clk);
    pix_bus.valid = 1'b1;
    pix_bus.channel_zero = px[7:0];
    pix_bus.channel_one = px[15:8];
    pix_bus.channel_two = px[23:16];
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    made = predict_edge(px, calc);
    if (made) edge_expected.push_back(typed ? typed_word : calc);
    n_words++;
  endtask

  task automatic note_fail(string why, edge_word_t want, edge_word_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: want edge %0d last %0b, got edge %0d last %0b", $time, why,
               want.edge_value, want.frame_last, got.edge_value, got.frame_last);
  endtask

  // result sink with random back-pressure
  initial begin
    edge_bus.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        edge_bus.ready = 1'b0;
        hold_left--;
      end else begin
        edge_bus.ready = 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 19))
            0:             hold_left = $urandom_range(20, 50);
            1, 2, 3, 4, 5: hold_left = $urandom_range(4, 12);
            default:       hold_left = $urandom_range(1, 3);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && edge_bus.valid && edge_bus.ready) begin
      seen_word.edge_value = edge_bus.edge_value;
      seen_word.frame_last = edge_bus.frame_last;
      if (edge_expected.size() == 0) begin
        note_fail("edge word with nothing due", '0, seen_word);
      end else begin
        due_word = edge_expected.pop_front();
        if (seen_word.edge_value !== due_word.edge_value ||
            seen_word.frame_last !== due_word.frame_last)
          note_fail("edge word mismatch", due_word, seen_word);
        n_checked++;
      end
    end
  end

  initial begin
    int         r, w, h, count, style, rand_words;
    edge_word_t row_word;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgMode;
    cfg_data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.channel_zero = '0;
    pix_bus.channel_one = '0;
    pix_bus.channel_two = '0;
    steady = 1'b0;
    flat_level = 120;
    fail_count = 0;
    n_words = 0;
    n_checked = 0;
    n_writes = 0;
    rand_words = 0;
    cur_mode = 1'b0;
    cur_width = 11'd640;
    cur_height = 16'd480;
    cur_thr = '0;
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    col_pos = 0;
    row_pos = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (StepTable[i]) begin
      if (StepTable[i].kind == RowCfg) begin
        write_reg(StepTable[i].idx, StepTable[i].data);
      end else begin
        row_word.edge_value = StepTable[i].want_edge;
        row_word.frame_last = StepTable[i].want_last;
        push_word(StepTable[i].px, StepTable[i].typed, row_word);
      end
    end

    while (rand_words < 1550) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) write_reg(CfgMode, CfgDataW'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 70) write_reg(CfgWidth, CfgDataW'($urandom_range(3, 10)));
        else if (r < 85) write_reg(CfgWidth, CfgDataW'($urandom_range(11, 40)));
        else if (r < 93) write_reg(CfgWidth, CfgDataW'($urandom_range(0, 2)));
        else write_reg(CfgWidth, 16'd3);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 70) write_reg(CfgHeight, CfgDataW'($urandom_range(3, 6)));
        else if (r < 82) write_reg(CfgHeight, CfgDataW'($urandom_range(0, 2)));
        else if (r < 92) write_reg(CfgHeight, CfgDataW'($urandom_range(7, 12)));
        else if (r < 96) write_reg(CfgHeight, 16'hFFFF);
        else write_reg(CfgHeight, CfgDataW'($urandom_range(1000, 65534)));
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 25) write_reg(CfgThresh, 16'd0);
        else if (r < 35) write_reg(CfgThresh, 16'd1023);
        else if (r < 65) write_reg(CfgThresh, CfgDataW'($urandom_range(0, 16)));
        else if (r < 85) write_reg(CfgThresh, CfgDataW'($urandom_range(0, 300)));
        else write_reg(CfgThresh, CfgDataW'($urandom_range(0, 1023)));
      end
      style = $urandom_range(0, 2);
      flat_level = $urandom_range(60, 180);
      w = eff_width();
      h = eff_height();
      if (w * h <= 240 && $urandom_range(0, 2) != 0) count = w * h * $urandom_range(1, 3);
      else count = w * $urandom_range(2, 5) + $urandom_range(0, w - 1);
      repeat (count) push_word(gen_pixel(style), 1'b0, '0);
      rand_words += count;
    end

    steady = 1'b0;
    @(negedge clk);
    pix_bus.valid = 1'b0;
    while (edge_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d pixel words over %0d register writes, gray and rgb modes",
             n_words, n_writes);
    $display("compared %0d edge words, %0d failures", n_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_laplacian4_edge_threshold OK");
    end else begin
      $display("tb_laplacian4_edge_threshold NOT OK");
    end
    $finish;
  end

endmodule

@@ laplacian4_edge_threshold.f @@
design/lap4et_pkg.sv
design/lap4et_if.sv
design/lap4et_line_mem.sv
design/lap4et_window.sv
design/lap4et_select.sv
design/laplacian4_edge_threshold.sv
tb/tb_laplacian4_edge_threshold.sv
